// File: design/sbq_pkg.sv
// Shared constants and types for the stereo biquad filter.
// Fixed-point formats and the coefficient register map; no dependencies.
package sbq_pkg;

	// Q2.21-style samples keep three integer bits, Q5.26-style coefficients six
	localparam int SAMPLE_INT_BITS = 3;
	localparam int COEF_INT_BITS   = 6;

	// growth of a sum of five products
	localparam int ACC_GUARD_BITS  = 3;

	localparam int CFG_IDX_BITS    = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		COEF_B0,
		COEF_B1,
		COEF_B2,
		COEF_A1,
		COEF_A2
	} coef_idx_t;

endpackage

// File: design/sbq_in_if.sv
// Input channel of the stereo biquad filter: one stereo frame per transaction.
// No dependencies.
interface sbq_in_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_left;
	logic signed [SAMPLE_BITS-1:0] sample_right;

	modport source (output valid, output sample_left, output sample_right, input ready);
	modport sink (input valid, input sample_left, input sample_right, output ready);
endinterface

// File: design/sbq_out_if.sv
// Output channel of the stereo biquad filter: one filtered frame per transaction.
// No dependencies.
interface sbq_out_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_left;
	logic signed [SAMPLE_BITS-1:0] out_right;

	modport source (output valid, output out_left, output out_right, input ready);
	modport sink (input valid, input out_left, input out_right, output ready);
endinterface

// File: design/stereo_biquad_filter_saturating_unit.sv
// Stereo biquad filter (direct form I) with input clamp and output saturation.
// Depends on sbq_pkg, sbq_in_if, sbq_out_if and sbq_lane.
//
//   channel    dir   payload                      transaction when
//   samples    in    sample_left, sample_right    valid && ready
//   filtered   out   out_left, out_right          valid && ready
//   cfg        in    cfg_index, cfg_wdata         cfg_we
//
// One frame per cycle sustained while the filtered output is not stalled.
// The input register feeds both lanes' multiply-accumulate, whose saturated result
// lands in the output register; the lane delay lines update as it loads.
// Reset loads b0 = 1.0, other coefficients and all delay lines to zero.
// A stalled output holds; the input register keeps accepting while the output
// register is empty or being drained.
module stereo_biquad_filter_saturating_unit #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	sbq_in_if.sink                               samples,
	sbq_out_if.source                            filtered,
	input  logic                                 cfg_we,
	input  logic [sbq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [COEF_BITS-1:0]                 cfg_wdata
);
	import sbq_pkg::*;

	localparam logic signed [COEF_BITS-1:0] COEF_ONE =
		COEF_BITS'(1) << (COEF_BITS - COEF_INT_BITS);

	logic signed [COEF_BITS-1:0]   coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;
	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] left_s1, right_s1;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_left_q, out_right_q;
	logic signed [SAMPLE_BITS-1:0] y_left, y_right;
	logic                          in_take, adv;

	assign adv     = valid_s1 && (!out_valid_q || filtered.ready);
	assign samples.ready = !valid_s1 || adv;
	assign in_take = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b0_q <= COEF_ONE;
			coef_b1_q <= '0;
			coef_b2_q <= '0;
			coef_a1_q <= '0;
			coef_a2_q <= '0;
		end else if (cfg_we) begin
			unique case (coef_idx_t'(cfg_index))
				COEF_B0: coef_b0_q <= cfg_wdata;
				COEF_B1: coef_b1_q <= cfg_wdata;
				COEF_B2: coef_b2_q <= cfg_wdata;
				COEF_A1: coef_a1_q <= cfg_wdata;
				COEF_A2: coef_a2_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (filtered.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			left_s1  <= samples.sample_left;
			right_s1 <= samples.sample_right;
		end
		if (adv) begin
			out_left_q  <= y_left;
			out_right_q <= y_right;
		end
	end

	sbq_lane #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS)
	) u_lane_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.x       (left_s1),
		.coef_b0 (coef_b0_q),
		.coef_b1 (coef_b1_q),
		.coef_b2 (coef_b2_q),
		.coef_a1 (coef_a1_q),
		.coef_a2 (coef_a2_q),
		.y       (y_left)
	);

	sbq_lane #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS)
	) u_lane_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.x       (right_s1),
		.coef_b0 (coef_b0_q),
		.coef_b1 (coef_b1_q),
		.coef_b2 (coef_b2_q),
		.coef_a1 (coef_a1_q),
		.coef_a2 (coef_a2_q),
		.y       (y_right)
	);

	assign filtered.valid     = out_valid_q;
	assign filtered.out_left  = out_left_q;
	assign filtered.out_right = out_right_q;
endmodule

// File: design/sbq_lane.sv
// One biquad lane: input clamp, five-tap multiply-accumulate, rounding, saturation,
// and the lane's own delay line. Depends on sbq_pkg.
module sbq_lane #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic signed [SAMPLE_BITS-1:0] x,
	input  logic signed [COEF_BITS-1:0]   coef_b0,
	input  logic signed [COEF_BITS-1:0]   coef_b1,
	input  logic signed [COEF_BITS-1:0]   coef_b2,
	input  logic signed [COEF_BITS-1:0]   coef_a1,
	input  logic signed [COEF_BITS-1:0]   coef_a2,
	output logic signed [SAMPLE_BITS-1:0] y
);
	import sbq_pkg::*;

	localparam int SAMPLE_FRAC = SAMPLE_BITS - SAMPLE_INT_BITS;
	localparam int COEF_FRAC   = COEF_BITS - COEF_INT_BITS;
	localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_BITS    = PROD_BITS + ACC_GUARD_BITS;

	localparam logic signed [SAMPLE_BITS-1:0] LIM_POS = SAMPLE_BITS'(1) << (SAMPLE_FRAC + 1);
	localparam logic signed [SAMPLE_BITS-1:0] LIM_NEG = -LIM_POS;
	localparam logic signed [ACC_BITS-1:0] LIM_POS_ACC = ACC_BITS'(1) << (SAMPLE_FRAC + 1);
	localparam logic signed [ACC_BITS-1:0] LIM_NEG_ACC = -LIM_POS_ACC;
	localparam logic signed [ACC_BITS-1:0] ROUND_HALF  = ACC_BITS'(1) << (COEF_FRAC - 1);

	logic signed [SAMPLE_BITS-1:0] x1_q, x2_q, y1_q, y2_q;
	logic signed [SAMPLE_BITS-1:0] xc;
	logic signed [PROD_BITS-1:0]   p_b0, p_b1, p_b2, p_a1, p_a2;
	logic signed [ACC_BITS-1:0]    acc, rnd, shf;

	always_comb begin
		if (x > LIM_POS) begin
			xc = LIM_POS;
		end else if (x < LIM_NEG) begin
			xc = LIM_NEG;
		end else begin
			xc = x;
		end
	end

	assign p_b0 = PROD_BITS'(xc) * PROD_BITS'(coef_b0);
	assign p_b1 = PROD_BITS'(x1_q) * PROD_BITS'(coef_b1);
	assign p_b2 = PROD_BITS'(x2_q) * PROD_BITS'(coef_b2);
	assign p_a1 = PROD_BITS'(y1_q) * PROD_BITS'(coef_a1);
	assign p_a2 = PROD_BITS'(y2_q) * PROD_BITS'(coef_a2);

	assign acc = ACC_BITS'(p_b0) + ACC_BITS'(p_b1) + ACC_BITS'(p_b2)
		- ACC_BITS'(p_a1) - ACC_BITS'(p_a2);
	// round half up, then floor shift
	assign rnd = acc + ROUND_HALF;
	assign shf = rnd >>> COEF_FRAC;

	always_comb begin
		if (shf > LIM_POS_ACC) begin
			y = LIM_POS;
		end else if (shf < LIM_NEG_ACC) begin
			y = LIM_NEG;
		end else begin
			y = SAMPLE_BITS'(shf);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (adv) begin
			x1_q <= xc;
			x2_q <= x1_q;
			y1_q <= y;
			y2_q <= y1_q;
		end
	end
endmodule
